[rtl/rfa_pkg.sv]
package rfa_pkg;

    localparam int POS_W    = 32;
    localparam int VEL_W    = 25;
    localparam int STAT_W   = 3;
    localparam int PCT_W    = 6;
    localparam int TICK_W   = 21;
    localparam int AMP_W    = 24;
    localparam int PEAK_W   = 31;
    localparam int MC_W     = 6;
    localparam int TO_W     = 20;
    localparam int AU_W     = 31;
    localparam int KU_W     = 40;
    localparam int KQ_W     = 31;
    localparam int KU_SHIFT = 22;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // round(4/pi * 2^30)
    localparam logic [KQ_W-1:0] KQ30 = 31'd1367130551;

    localparam logic [TICK_W-1:0] ELAPSED_MAX = '1;

    localparam logic [AMP_W-1:0]  AMP_RST     = 24'd5000;
    localparam logic [PEAK_W-1:0] MAX_PEAK_RST = 31'd50000;
    localparam logic [MC_W-1:0]   MIN_CYC_RST = 6'd10;
    localparam logic [TO_W-1:0]   TIMEOUT_RST = 20'd30000;

    localparam logic [PCT_W-1:0] PROG_BASE = 6'd5;
    localparam logic [PCT_W-1:0] PROG_SPAN = 6'd30;
    localparam logic [PCT_W-1:0] PROG_MAX  = 6'd35;

    localparam int MIN_CROSS = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AMP      = 2'd0,
        CFG_MAX_PEAK = 2'd1,
        CFG_MIN_CYC  = 2'd2,
        CFG_TIMEOUT  = 2'd3
    } t_cfg_idx;

    typedef enum logic [STAT_W-1:0] {
        ST_RUNNING  = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_PEAK     = 3'd2,
        ST_TIMEOUT  = 3'd3,
        ST_FEW      = 3'd4,
        ST_INVALID  = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        PH_FIRST    = 4'b0001,
        PH_RUN      = 4'b0010,
        PH_COMPUTE  = 4'b0100,
        PH_FINISHED = 4'b1000
    } t_phase;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LOAD  = 9'b000000010,
        S_CROSS = 9'b000000100,
        S_PEAK  = 9'b000001000,
        S_CHECK = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_MUL1  = 9'b001000000,
        S_MUL2  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {
        OP_PROG = 2'd0,
        OP_TU   = 2'd1,
        OP_AU   = 2'd2,
        OP_KU   = 2'd3
    } t_div_op;

endpackage

[rtl/rfa_if.sv]
interface rfa_in_if import rfa_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic                    restart;
    logic signed [POS_W-1:0] position;

    modport source (output valid, output restart, output position, input ready);
    modport sink   (input valid, input restart, input position, output ready);
endinterface

interface rfa_out_if import rfa_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] velocity_command;
    logic [STAT_W-1:0]       status;
    logic [PCT_W-1:0]        progress;
    logic [TICK_W-1:0]       period_ticks;
    logic [AU_W-1:0]         amplitude;
    logic [KU_W-1:0]         ultimate_gain;

    modport source (output valid, output velocity_command, output status, output progress,
                    output period_ticks, output amplitude, output ultimate_gain, input ready);
    modport sink   (input valid, input velocity_command, input status, input progress,
                    input period_ticks, input amplitude, input ultimate_gain, output ready);
endinterface

[rtl/relay_feedback_autotune.sv]
// The first tick and finished ticks go from S_LOAD straight to S_OUT; a tick without
// a crossing passes S_CROSS and S_CHECK, a crossing tick a progress divide if the
// minimum cycle count is nonzero, and the completion tick the Tu, Au and Ku divides
// through one shared restoring divider. A result that waits adds its stall.
// Throughput: one transaction at a time; the next is taken while a result waits.
// Reset (i_rst_n, synchronous): registers at defaults, test restarts at the first tick.
module relay_feedback_autotune import rfa_pkg::*; #(
    parameter int MAX_CROSSINGS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    rfa_in_if.sink                i_in,
    rfa_out_if.source             o_out
);

    localparam int CNT_W   = $clog2(MAX_CROSSINGS + 1);
    localparam int PS_W    = PEAK_W + CNT_W;
    localparam int PROD1_W = AMP_W + CNT_W;
    localparam int NUM_W   = PROD1_W + KQ_W;
    localparam int DEN_W   = PS_W + KU_SHIFT;
    localparam int REM_W   = DEN_W + 1;
    localparam int IT_W    = $clog2(NUM_W + 1);
    localparam int PRG_W   = CNT_W + 4;
    localparam int TOT_W   = TICK_W + 1;
    localparam int ERR_W   = POS_W + 1;
    localparam int CMP_W   = (CNT_W > MC_W + 1) ? CNT_W : MC_W + 1;

    // configuration
    logic [AMP_W-1:0]  r_amp;
    logic [PEAK_W-1:0] r_max_peak;
    logic [MC_W-1:0]   r_min_cycles;
    logic [TO_W-1:0]   r_timeout;

    // sequencer and test state
    t_state                  r_state;
    t_phase                  r_phase;
    t_status                 r_status;
    t_div_op                 r_div_op;
    logic signed [POS_W-1:0] r_centre;
    logic                    r_sign;
    logic [CNT_W-1:0]        r_cnt;
    logic [TICK_W-1:0]       r_elapsed;
    logic [TICK_W-1:0]       r_first;
    logic [TICK_W-1:0]       r_last;
    logic [PS_W-1:0]         r_ps;
    logic [PCT_W-1:0]        r_progress;
    logic [TICK_W-1:0]       r_res_tu;
    logic [AU_W-1:0]         r_res_au;
    logic [KU_W-1:0]         r_res_ku;

    // working registers
    logic                    r_in_restart;
    logic signed [POS_W-1:0] r_in_pos;
    logic signed [ERR_W-1:0] r_err;
    logic [POS_W-1:0]        r_peak;
    logic signed [VEL_W-1:0] r_vel;
    logic [PROD1_W-1:0]      r_prod1;
    logic [NUM_W-1:0]        r_num;
    logic [REM_W-1:0]        r_rem;
    logic [DEN_W-1:0]        r_den;
    logic [IT_W-1:0]         r_div_cnt;

    // output register
    logic                    r_out_valid;
    logic signed [VEL_W-1:0] r_o_vel;
    logic [STAT_W-1:0]       r_o_status;
    logic [PCT_W-1:0]        r_o_progress;
    logic [TICK_W-1:0]       r_o_tu;
    logic [AU_W-1:0]         r_o_au;
    logic [KU_W-1:0]         r_o_ku;

    t_phase                  phase_eff;
    logic [TICK_W-1:0]       n_elapsed;
    logic signed [ERR_W-1:0] err_w;
    logic                    err_neg;
    logic                    flip;
    logic [ERR_W-1:0]        err_abs;
    logic [CNT_W-1:0]        cnt_m2;
    logic [CNT_W-1:0]        cnt_m1;
    logic [TICK_W-1:0]       total;
    logic [TOT_W-1:0]        tot2;
    logic [PS_W+3:0]         ps10;
    logic                    res_invalid;
    logic [PRG_W-1:0]        half_cnt;
    logic [PRG_W-1:0]        prog_num;
    logic [PRG_W-1:0]        prog_q;
    logic [PROD1_W-1:0]      prod1_w;
    logic [NUM_W-1:0]        prod2_w;
    logic [REM_W-1:0]        rem_sh;
    logic [REM_W-1:0]        rem_sub;
    logic                    q_bit;
    logic signed [VEL_W-1:0] amp_vel;
    logic                    go_compute;

    assign phase_eff = r_in_restart ? PH_FIRST : r_phase;
    assign n_elapsed = (r_elapsed < ELAPSED_MAX) ? r_elapsed + 1'b1 : r_elapsed;
    assign err_w     = ERR_W'(r_in_pos) - ERR_W'(r_centre);
    assign err_neg   = r_err[ERR_W-1];
    assign flip      = r_sign ? err_neg : (!err_neg && (r_err != '0));
    assign err_abs   = err_neg ? ERR_W'(-r_err) : ERR_W'(r_err);

    assign cnt_m2 = r_cnt - CNT_W'(2);
    assign cnt_m1 = r_cnt - CNT_W'(1);
    assign total  = r_last - r_first;
    assign tot2   = {total, 1'b0};
    assign ps10   = (PS_W + 4)'({r_ps, 3'b000}) + (PS_W + 4)'({r_ps, 1'b0});
    assign res_invalid = (tot2 <= TOT_W'(cnt_m1)) || (ps10 <= (PS_W + 4)'(cnt_m2))
                       || (r_amp == '0);

    assign half_cnt = PRG_W'(r_cnt[CNT_W-1:1]);
    assign prog_num = (half_cnt << 5) - (half_cnt << 1);
    assign prog_q   = r_num[PRG_W-1:0];

    assign prod1_w = r_amp * cnt_m2;
    assign prod2_w = r_prod1 * KQ30;

    assign rem_sh  = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
    assign q_bit   = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    assign amp_vel    = VEL_W'(r_amp);
    assign go_compute = (CMP_W'(r_cnt) >= CMP_W'({r_min_cycles, 1'b0}))
                     || (r_cnt >= CNT_W'(MAX_CROSSINGS));

    assign i_in.ready             = (r_state == S_IDLE);
    assign o_out.valid            = r_out_valid;
    assign o_out.velocity_command = r_o_vel;
    assign o_out.status           = r_o_status;
    assign o_out.progress         = r_o_progress;
    assign o_out.period_ticks     = r_o_tu;
    assign o_out.amplitude        = r_o_au;
    assign o_out.ultimate_gain    = r_o_ku;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp        <= AMP_RST;
            r_max_peak   <= MAX_PEAK_RST;
            r_min_cycles <= MIN_CYC_RST;
            r_timeout    <= TIMEOUT_RST;
            r_state      <= S_IDLE;
            r_phase      <= PH_FIRST;
            r_status     <= ST_RUNNING;
            r_div_op     <= OP_PROG;
            r_centre     <= '0;
            r_sign       <= 1'b0;
            r_cnt        <= '0;
            r_elapsed    <= '0;
            r_first      <= '0;
            r_last       <= '0;
            r_ps         <= '0;
            r_progress   <= '0;
            r_res_tu     <= '0;
            r_res_au     <= '0;
            r_res_ku     <= '0;
            r_in_restart <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_AMP:      r_amp        <= i_cfg_wdata[AMP_W-1:0];
                    CFG_MAX_PEAK: r_max_peak   <= i_cfg_wdata[PEAK_W-1:0];
                    CFG_MIN_CYC:  r_min_cycles <= i_cfg_wdata[MC_W-1:0];
                    CFG_TIMEOUT:  r_timeout    <= i_cfg_wdata[TO_W-1:0];
                endcase
            end

            if (r_out_valid && o_out.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_in_restart <= i_in.restart;
                        r_in_pos     <= i_in.position;
                        r_state      <= S_LOAD;
                    end
                end

                S_LOAD: begin
                    unique case (phase_eff)
                        PH_FIRST: begin
                            r_centre   <= r_in_pos;
                            r_sign     <= 1'b0;
                            r_cnt      <= '0;
                            r_elapsed  <= TICK_W'(1);
                            r_first    <= '0;
                            r_last     <= '0;
                            r_ps       <= '0;
                            r_res_tu   <= '0;
                            r_res_au   <= '0;
                            r_res_ku   <= '0;
                            r_progress <= PROG_BASE;
                            r_status   <= ST_RUNNING;
                            r_phase    <= PH_RUN;
                            r_vel      <= amp_vel;
                            r_state    <= S_OUT;
                        end
                        PH_RUN: begin
                            r_elapsed <= n_elapsed;
                            r_err     <= err_w;
                            r_state   <= S_CROSS;
                        end
                        PH_COMPUTE: begin
                            r_vel <= '0;
                            if (r_cnt < CNT_W'(MIN_CROSS)) begin
                                r_status <= ST_FEW;
                                r_phase  <= PH_FINISHED;
                                r_state  <= S_OUT;
                            end else if (res_invalid) begin
                                r_status <= ST_INVALID;
                                r_phase  <= PH_FINISHED;
                                r_state  <= S_OUT;
                            end else begin
                                r_num     <= NUM_W'(tot2);
                                r_den     <= DEN_W'(cnt_m1);
                                r_rem     <= '0;
                                r_div_cnt <= IT_W'(NUM_W);
                                r_div_op  <= OP_TU;
                                r_state   <= S_DIV;
                            end
                        end
                        PH_FINISHED: begin
                            r_vel   <= '0;
                            r_state <= S_OUT;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end

                S_CROSS: begin
                    if (flip) begin
                        r_peak <= err_abs[POS_W-1:0];
                        r_sign <= !r_sign;
                        if (r_cnt == '0) begin
                            r_first <= r_elapsed;
                        end
                        r_last  <= r_elapsed;
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_PEAK;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end

                S_PEAK: begin
                    if (r_peak > POS_W'(r_max_peak)) begin
                        r_status <= ST_PEAK;
                        r_phase  <= PH_FINISHED;
                        r_vel    <= '0;
                        r_state  <= S_OUT;
                    end else begin
                        if (r_cnt > CNT_W'(2)) begin
                            r_ps <= r_ps + PS_W'(r_peak[PEAK_W-1:0]);
                        end
                        if (r_min_cycles == '0) begin
                            r_progress <= PROG_MAX;
                            r_state    <= S_CHECK;
                        end else begin
                            r_num     <= {prog_num, {(NUM_W - PRG_W){1'b0}}};
                            r_den     <= DEN_W'(r_min_cycles);
                            r_rem     <= '0;
                            r_div_cnt <= IT_W'(PRG_W);
                            r_div_op  <= OP_PROG;
                            r_state   <= S_DIV;
                        end
                    end
                end

                S_CHECK: begin
                    priority if (r_elapsed > TICK_W'(r_timeout)) begin
                        r_status <= ST_TIMEOUT;
                        r_phase  <= PH_FINISHED;
                        r_vel    <= '0;
                    end else begin
                        if (go_compute) begin
                            r_phase <= PH_COMPUTE;
                        end
                        r_vel <= r_sign ? -amp_vel : amp_vel;
                    end
                    r_state <= S_OUT;
                end

                S_DIV: begin
                    if (r_div_cnt != '0) begin
                        r_rem     <= q_bit ? rem_sub : rem_sh;
                        r_num     <= {r_num[NUM_W-2:0], q_bit};
                        r_div_cnt <= r_div_cnt - 1'b1;
                    end else begin
                        unique case (r_div_op)
                            OP_PROG: begin
                                if (prog_q > PRG_W'(PROG_SPAN)) begin
                                    r_progress <= PROG_MAX;
                                end else begin
                                    r_progress <= PROG_BASE + prog_q[PCT_W-1:0];
                                end
                                r_state <= S_CHECK;
                            end
                            OP_TU: begin
                                r_res_tu  <= r_num[TICK_W-1:0];
                                r_num     <= NUM_W'(r_ps);
                                r_den     <= DEN_W'(cnt_m2);
                                r_rem     <= '0;
                                r_div_cnt <= IT_W'(NUM_W);
                                r_div_op  <= OP_AU;
                            end
                            OP_AU: begin
                                r_res_au <= r_num[AU_W-1:0];
                                r_state  <= S_MUL1;
                            end
                            OP_KU: begin
                                r_res_ku   <= r_num[KU_W-1:0];
                                r_progress <= PROG_MAX;
                                r_status   <= ST_COMPLETE;
                                r_phase    <= PH_FINISHED;
                                r_state    <= S_OUT;
                            end
                        endcase
                    end
                end

                S_MUL1: begin
                    r_prod1 <= prod1_w;
                    r_state <= S_MUL2;
                end

                S_MUL2: begin
                    r_num     <= prod2_w;
                    r_den     <= {r_ps, {KU_SHIFT{1'b0}}};
                    r_rem     <= '0;
                    r_div_cnt <= IT_W'(NUM_W);
                    r_div_op  <= OP_KU;
                    r_state   <= S_DIV;
                end

                S_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_o_vel      <= r_vel;
                        r_o_status   <= r_status;
                        r_o_progress <= r_progress;
                        r_o_tu       <= r_res_tu;
                        r_o_au       <= r_res_au;
                        r_o_ku       <= r_res_ku;
                        r_state      <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_finished_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FINISHED) |-> (r_status != ST_RUNNING))
        else $error("finished test without a final status");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < {1'b0, r_den}))
        else $error("divider remainder not below divisor");

    a_complete_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status == ST_COMPLETE) |-> (r_progress == PROG_MAX))
        else $error("complete status without full progress");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_LOAD))
        else $error("accepted transaction not started");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_CROSSINGS))
        else $error("crossing count past limit");

endmodule

[tb/sv/autotune_checker.sv]
`timescale 1ns / 100ps
module autotune_checker import rfa_pkg::*; #(
    parameter int MAX_CROSSINGS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    rfa_in_if                     i_in,
    rfa_out_if                    i_out,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct {
        logic signed [VEL_W-1:0] vel;
        t_status                 status;
        logic [PCT_W-1:0]        pct;
        logic [TICK_W-1:0]       tu;
        logic [AU_W-1:0]         au;
        logic [KU_W-1:0]         ku;
    } t_tick_result;

    logic [AMP_W-1:0]  relay_amp;
    logic [PEAK_W-1:0] peak_limit;
    logic [MC_W-1:0]   cycles_req;
    logic [TO_W-1:0]   tick_limit;

    t_phase            phase;
    longint            centre;
    bit                drive_neg;
    int                crossings;
    int                elapsed;
    int                first_cross;
    int                last_cross;
    longint unsigned   peak_sum;
    logic [TICK_W-1:0] tu_q;
    logic [AU_W-1:0]   au_q;
    logic [KU_W-1:0]   ku_q;
    logic [PCT_W-1:0]  pct_q;
    t_status           status_q;

    t_tick_result expected_ticks[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void reset_model();
        relay_amp   = AMP_RST;
        peak_limit  = MAX_PEAK_RST;
        cycles_req  = MIN_CYC_RST;
        tick_limit  = TIMEOUT_RST;
        phase       = PH_FIRST;
        centre      = 0;
        drive_neg   = 1'b0;
        crossings   = 0;
        elapsed     = 0;
        first_cross = 0;
        last_cross  = 0;
        peak_sum    = 0;
        tu_q        = '0;
        au_q        = '0;
        ku_q        = '0;
        pct_q       = '0;
        status_q    = ST_RUNNING;
    endfunction

    // Completion tick: final status and, if valid, Tu, Au and Ku from the crossing record.
    function automatic void settle_results();
        longint unsigned n;
        longint unsigned m;
        longint unsigned total;
        longint unsigned d;
        n = 64'(crossings);
        d = 64'(relay_amp);
        if (n < MIN_CROSS) begin
            status_q = ST_FEW;
        end else begin
            total = 64'(last_cross - first_cross);
            m     = n - 2;
            if (2 * total <= n - 1 || 10 * peak_sum <= m || d == 0) begin
                status_q = ST_INVALID;
            end else begin
                tu_q     = TICK_W'((2 * total) / (n - 1));
                au_q     = AU_W'(peak_sum / m);
                ku_q     = KU_W'((d * m * KQ30) / (peak_sum << KU_SHIFT));
                pct_q    = PROG_MAX;
                status_q = ST_COMPLETE;
            end
        end
        phase = PH_FINISHED;
    endfunction

    function automatic t_tick_result tune_step(input bit rs, input logic signed [POS_W-1:0] p);
        t_tick_result            r;
        longint                  err;
        longint unsigned         peak;
        bit                      flip;
        bit                      peak_fail;
        int                      pc;
        logic signed [VEL_W-1:0] d_vel;
        d_vel     = {1'b0, relay_amp};
        r.vel     = '0;
        peak_fail = 1'b0;
        if (rs) begin
            phase = PH_FIRST;
        end
        case (phase)
            PH_FIRST: begin
                centre      = 64'(p);
                drive_neg   = 1'b0;
                crossings   = 0;
                elapsed     = 1;
                first_cross = 0;
                last_cross  = 0;
                peak_sum    = 0;
                tu_q        = '0;
                au_q        = '0;
                ku_q        = '0;
                pct_q       = PROG_BASE;
                status_q    = ST_RUNNING;
                phase       = PH_RUN;
                r.vel       = d_vel;
            end
            PH_COMPUTE: begin
                settle_results();
            end
            PH_RUN: begin
                if (elapsed < ELAPSED_MAX) begin
                    elapsed++;
                end
                err  = 64'(p) - centre;
                flip = drive_neg ? (err < 0) : (err > 0);
                if (flip) begin
                    peak      = (err < 0) ? -err : err;
                    drive_neg = !drive_neg;
                    if (crossings == 0) begin
                        first_cross = elapsed;
                    end
                    last_cross = elapsed;
                    crossings++;
                    if (peak > peak_limit) begin
                        status_q  = ST_PEAK;
                        phase     = PH_FINISHED;
                        peak_fail = 1'b1;
                    end else begin
                        if (crossings > 2) begin
                            peak_sum += peak;
                        end
                        if (cycles_req == 0) begin
                            pct_q = PROG_MAX;
                        end else begin
                            pc    = PROG_BASE + ((crossings / 2) * PROG_SPAN) / int'(cycles_req);
                            pct_q = (pc > PROG_MAX) ? PROG_MAX : PCT_W'(pc);
                        end
                    end
                end
                if (!peak_fail) begin
                    if (crossings >= 2 * int'(cycles_req) || crossings >= MAX_CROSSINGS) begin
                        phase = PH_COMPUTE;
                    end
                    if (elapsed > tick_limit) begin
                        status_q = ST_TIMEOUT;
                        phase    = PH_FINISHED;
                    end else begin
                        r.vel = drive_neg ? -d_vel : d_vel;
                    end
                end
            end
            default: begin
                r.vel = '0;
            end
        endcase
        r.status = status_q;
        r.pct    = pct_q;
        r.tu     = tu_q;
        r.au     = au_q;
        r.ku     = ku_q;
        return r;
    endfunction

    task automatic report(input string msg);
        $display("%0t: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic signed [63:0] got,
                               input logic signed [63:0] want);
        if (got !== want) begin
            report($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
        end
    endtask

    task automatic check_result();
        t_tick_result want;
        if (expected_ticks.size() == 0) begin
            report("result transaction with no tick outstanding");
            return;
        end
        want = expected_ticks.pop_front();
        check_field("velocity_command", i_out.velocity_command, want.vel);
        check_field("status", i_out.status, want.status);
        check_field("progress", i_out.progress, want.pct);
        check_field("period_ticks", i_out.period_ticks, want.tu);
        check_field("amplitude", i_out.amplitude, want.au);
        check_field("ultimate_gain", i_out.ultimate_gain, want.ku);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            expected_ticks.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_AMP:      relay_amp  = i_cfg_wdata[AMP_W-1:0];
                    CFG_MAX_PEAK: peak_limit = i_cfg_wdata[PEAK_W-1:0];
                    CFG_MIN_CYC:  cycles_req = i_cfg_wdata[MC_W-1:0];
                    CFG_TIMEOUT:  tick_limit = i_cfg_wdata[TO_W-1:0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                check_result();
            end
            if (i_in.valid && i_in.ready) begin
                expected_ticks.push_back(tune_step(i_in.restart, i_in.position));
            end
        end
        o_pending <= expected_ticks.size();
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
module testbench;
    import rfa_pkg::*;

    localparam int MAX_CROSSINGS = 64;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int DRAIN_CYCLES  = 250;
    localparam int PHASE_ITEMS   = 125;
    localparam int N_PHASES      = 12;

    typedef enum {RDY_OPEN, RDY_CHOPPY, RDY_SLOW} t_ready_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int          fail_count;
    int          pending;
    int          cycles      = 0;
    int          burst_left  = 0;
    int          ready_hold  = 0;
    int          item_count  = 0;
    t_ready_mode ready_mode  = RDY_OPEN;

    logic [AMP_W-1:0]  cur_amp;
    logic [PEAK_W-1:0] cur_peak;
    logic [MC_W-1:0]   cur_mc;
    logic [TO_W-1:0]   cur_to;

    rfa_in_if  in_ch();
    rfa_out_if out_ch();

    relay_feedback_autotune #(
        .MAX_CROSSINGS (MAX_CROSSINGS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    autotune_checker #(
        .MAX_CROSSINGS (MAX_CROSSINGS)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("relay_feedback_autotune verification failed");
            $finish;
        end
    end

    // result-side backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (ready_hold == 0) begin
                ready_mode = t_ready_mode'($urandom_range(0, 2));
                ready_hold = $urandom_range(20, 200);
            end else begin
                ready_hold--;
            end
            case (ready_mode)
                RDY_OPEN:   out_ch.ready <= 1'b1;
                RDY_CHOPPY: out_ch.ready <= 1'($urandom_range(0, 1));
                default:    out_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return POS_W'(v);
    endfunction

    task automatic send_tick(input bit rs, input logic signed [POS_W-1:0] p);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid    <= 1'b1;
        in_ch.restart  <= rs;
        in_ch.position <= p;
        do @(posedge i_clk); while (!in_ch.ready);
        item_count++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic load_tuning(input logic [AMP_W-1:0] amp, input logic [PEAK_W-1:0] pk,
                               input logic [MC_W-1:0] mc, input logic [TO_W-1:0] to);
        cur_amp   = amp;
        cur_peak  = pk;
        cur_mc    = mc;
        cur_to    = to;
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_AMP;
        cfg_wdata <= CFG_DATA_W'(amp);
        @(posedge i_clk);
        cfg_idx   <= CFG_MAX_PEAK;
        cfg_wdata <= CFG_DATA_W'(pk);
        @(posedge i_clk);
        cfg_idx   <= CFG_MIN_CYC;
        cfg_wdata <= CFG_DATA_W'(mc);
        @(posedge i_clk);
        cfg_idx   <= CFG_TIMEOUT;
        cfg_wdata <= CFG_DATA_W'(to);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // One relay test: restart on a centre, then alternating crossings with
    // dwell samples on the far side, then a few trailing samples.
    task automatic run_oscillation();
        longint centre;
        longint ok_hi;
        longint sgn;
        longint pk;
        longint off;
        int     target;
        int     n_half;
        int     dwell_max;
        int     bad_at;
        int     k;
        int     j;
        if ($urandom_range(0, 4) == 0) begin
            centre = longint'($signed($urandom));
        end else begin
            centre = longint'($urandom_range(0, 2000000)) - 1000000;
        end
        ok_hi  = (cur_peak == 0) ? 1 : ((cur_peak < 3000) ? cur_peak : 3000);
        target = 2 * int'(cur_mc);
        if (target > MAX_CROSSINGS) begin
            target = MAX_CROSSINGS;
        end
        if (target == 0) begin
            target = 2;
        end
        if ($urandom_range(0, 4) == 0) begin
            n_half = $urandom_range(0, target);
        end else begin
            n_half = target + $urandom_range(0, 2);
        end
        bad_at    = ($urandom_range(0, 6) == 0) ? $urandom_range(0, n_half) : -1;
        dwell_max = $urandom_range(0, 4);
        send_tick(1'b1, clamp_pos(centre));
        sgn = 1;
        for (k = 0; k < n_half; k++) begin
            for (j = $urandom_range(0, dwell_max); j > 0; j--) begin
                off = longint'($urandom_range(0, 32'(ok_hi)));
                send_tick(1'b0, clamp_pos(centre - sgn * off));
            end
            if (k == bad_at) begin
                off = longint'($urandom_range(1, 32'h3FFF_FFFF));
                pk  = ok_hi + off;
            end else begin
                pk = longint'($urandom_range(1, 32'(ok_hi)));
            end
            send_tick(1'b0, clamp_pos(centre + sgn * pk));
            sgn = -sgn;
        end
        for (j = $urandom_range(1, 3); j > 0; j--) begin
            send_tick(1'($urandom_range(0, 7) == 0), $signed($urandom));
        end
    endtask

    initial begin
        int ph;
        int start;
        logic [AMP_W-1:0]  amp;
        logic [PEAK_W-1:0] pk;
        logic [MC_W-1:0]   mc;
        logic [TO_W-1:0]   to;

        i_rst_n        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= CFG_AMP;
        cfg_wdata      <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.restart  <= 1'b0;
        in_ch.position <= '0;
        cur_amp  = AMP_RST;
        cur_peak = MAX_PEAK_RST;
        cur_mc   = MIN_CYC_RST;
        cur_to   = TIMEOUT_RST;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // position extremes; first tick after reset without restart
        send_tick(1'b0, 32'sh8000_0000);
        send_tick(1'b0, 32'sh7FFF_FFFF);
        send_tick(1'b0, 32'sd0);
        send_tick(1'b1, 32'sh7FFF_FFFF);
        send_tick(1'b0, 32'sh8000_0000);
        send_tick(1'b0, 32'sh7FFF_FFFF);
        wait_drained();

        // short complete test, peak exactly at the limit, then one just over
        load_tuning(AMP_RST, MAX_PEAK_RST, 6'd3, TIMEOUT_RST);
        send_tick(1'b1, 100);
        send_tick(1'b0, 100);
        send_tick(1'b0, 50100);
        send_tick(1'b0, 200);
        send_tick(1'b0, -900);
        send_tick(1'b0, 1100);
        send_tick(1'b0, -1);
        send_tick(1'b0, 301);
        send_tick(1'b0, -199);
        send_tick(1'b0, 0);
        send_tick(1'b0, 5);
        send_tick(1'b1, 0);
        send_tick(1'b0, 50001);
        send_tick(1'b0, 7);
        wait_drained();

        for (ph = 0; ph < N_PHASES; ph++) begin
            amp = AMP_W'($urandom_range(0, 24'hFF_FFFF));
            pk  = $urandom_range(0, 1) ? PEAK_W'($urandom_range(100, 200000))
                                       : PEAK_W'($urandom);
            mc  = MC_W'($urandom_range(3, 12));
            to  = TO_W'($urandom_range(40, 3000));
            case (ph)
                0: begin amp = AMP_RST; pk = MAX_PEAK_RST; mc = MIN_CYC_RST; to = TIMEOUT_RST; end
                1: begin amp = '1; pk = '1; mc = 6'd3; to = '1; end
                2: begin amp = '0; pk = 31'd20000; mc = 6'd4; to = 20'd5000; end
                3: begin amp = 24'd1; pk = '0; mc = 6'd5; to = 20'd1000; end
                4: begin amp = 24'd3000; pk = 31'd1000; mc = 6'd32; to = '1; end
                5: begin pk = MAX_PEAK_RST; mc = 6'd0; to = TIMEOUT_RST; end
                6: begin pk = 31'd100000; mc = 6'd63; to = 20'd500; end
                7: begin mc = 6'd2; to = 20'd100; end
                8: begin mc = 6'd1; to = 20'd1; end
                default: ;
            endcase
            load_tuning(amp, pk, mc, to);
            start = item_count;
            while (item_count - start < PHASE_ITEMS) begin
                run_oscillation();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("relay_feedback_autotune verification clean");
        end else begin
            $display("relay_feedback_autotune verification failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/rfa_pkg.sv
rtl/rfa_if.sv
rtl/relay_feedback_autotune.sv
tb/sv/autotune_checker.sv
tb/sv/testbench.sv
